[rtl/par_pkg.sv]
// Shared types and constants of the point rotator.
// Holds the angle conversion constants, the CORDIC arctangent table and the
// structs that travel along the pipeline. Depends on nothing.
package par_pkg;

	localparam int COORD_W     = 32;
	localparam int GUARD_BITS  = 8;
	localparam int GAIN_BITS   = 20;
	localparam int CORDIC_W    = 46;
	localparam int ANGLE_W     = 34;
	localparam int TURN_DIGITS = 4;

	// Angle conversion: high part of the degree value reduced modulo 360.
	localparam int HU_W       = 25;
	localparam int HU_SHIFT   = 26;
	localparam int HPROD_W    = 43;
	localparam logic [HU_W-1:0] HU_OFFSET = 25'd8388720;
	localparam logic [17:0]     HU_RECIP  = 18'd186413;

	// One radix-256 digit of the turn quotient.
	localparam int DIG_W      = 8;
	localparam int REM_W      = 9;
	localparam int MOD_W      = 10;
	localparam int DIG_V_W    = 17;
	localparam int DIG_PROD_W = 32;
	localparam int DIG_SHIFT  = 24;
	localparam logic [15:0]      DIG_RECIP = 16'd46603;
	localparam logic [MOD_W-1:0] DEG_MOD   = 10'd360;
	localparam logic [COORD_W-1:0] LOW_BIAS = 32'd180;

	localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 34'sd2147483648;

	localparam logic [GAIN_BITS-1:0] GAIN_K = 20'd636751;

	localparam logic [31:0] ATAN_TURN [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// Data that rides along with an item: axis, original point and the
	// centre coordinates of the rotation plane.
	typedef struct packed {
		axis_t                      axis;
		logic signed [COORD_W-1:0] pt_x;
		logic signed [COORD_W-1:0] pt_y;
		logic signed [COORD_W-1:0] pt_z;
		logic signed [COORD_W-1:0] cen_c;
		logic signed [COORD_W-1:0] cen_s;
	} side_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] new_x;
		logic signed [COORD_W-1:0] new_y;
		logic signed [COORD_W-1:0] new_z;
		logic                      saturated;
	} result_t;

endpackage

[rtl/point_axis_rotator.sv]
// Rotates a 3D point about the X, Y or Z axis through a centre point.
// Top level: angle conversion front end, CORDIC cell chain, gain stage and
// output buffer. Depends on par_pkg, par_div_cell, par_cordic_cell, par_gain.
//
// Usage: one transaction on the s_ side carries the point, the centre and the
// angle in s_tdata and the axis code in s_tuser. For each one, exactly one
// transaction on the m_ side returns the rotated point, with the clamp flag
// in m_tuser. An axis code of 3 returns the point unchanged.
// Along the pipeline, the angle's high part is first reduced modulo 360, then
// the divider cells produce the 32-bit turn one byte per divider cell, then
// the quadrant is folded, then the vector passes each CORDIC cell, then gain,
// centre add and saturation follow, and last the output register. One
// transaction is taken every cycle while the skid register is empty.
// Reset empties the whole pipeline; no results are pending after it.
// When the receiver stalls, the result in the output register holds and the
// next one lands in a skid register; only while the skid register is full
// does s_tready drop and the whole pipeline freeze.
module point_axis_rotator
	import par_pkg::*;
#(
	parameter int CORDIC_STAGES = 16,
	parameter int FRAC_BITS     = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_x, point_y, point_z, centre_x, centre_y, centre_z, angle_deg
	input  logic [223:0] s_tdata,
	// cmd
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// new_x, new_y, new_z
	output logic [95:0]  m_tdata,
	// saturated
	output logic [0:0]   m_tuser
);

	logic pipe_en;

	// Input stage: split the angle and choose the plane centre.
	logic signed [COORD_W-1:0] ang;
	logic signed [COORD_W-1:0] ang_hi;
	logic [HU_W-1:0]           hu;
	logic [COORD_W-1:0]        ang_lo;
	side_t                     side_in;

	logic               valid_s1;
	side_t              side_s1;
	logic [HU_W-1:0]    hu_s1;
	logic [COORD_W-1:0] low_s1;

	logic               valid_s2;
	side_t              side_s2;
	logic [HPROD_W-1:0] hprod_s2;
	logic [MOD_W-1:0]   hu_lo_s2;
	logic [COORD_W-1:0] low_s2;

	logic [MOD_W-1:0]   hq_lo;
	logic [MOD_W-1:0]   hr_est;
	logic [MOD_W-1:0]   hr_fix;

	logic               valid_s3;
	side_t              side_s3;
	logic [REM_W-1:0]   rem_s3;
	logic [COORD_W-1:0] low_s3;

	logic               d_valid [TURN_DIGITS+1];
	side_t              d_side  [TURN_DIGITS+1];
	logic [REM_W-1:0]   d_rem   [TURN_DIGITS+1];
	logic [COORD_W-1:0] d_low   [TURN_DIGITS+1];
	logic [COORD_W-1:0] d_quo   [TURN_DIGITS+1];

	// Quadrant fold and plane differences.
	logic signed [ANGLE_W-1:0]  z_turn;
	logic signed [ANGLE_W-1:0]  z_fold;
	logic                       flip;
	logic signed [COORD_W-1:0]  pc;
	logic signed [COORD_W-1:0]  ps;
	logic signed [COORD_W:0]    dc;
	logic signed [COORD_W:0]    ds;
	logic signed [COORD_W:0]    dc_f;
	logic signed [COORD_W:0]    ds_f;

	logic                       c_valid [CORDIC_STAGES+1];
	side_t                      c_side  [CORDIC_STAGES+1];
	logic signed [CORDIC_W-1:0] c_x     [CORDIC_STAGES+1];
	logic signed [CORDIC_W-1:0] c_y     [CORDIC_STAGES+1];
	logic signed [ANGLE_W-1:0]  c_z     [CORDIC_STAGES+1];

	logic    g_valid;
	result_t g_res;

	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;

	assign pipe_en  = !skid_valid_q;
	assign s_tready = pipe_en;

	// The angle is a*2^(32-F) + 180 over 360. Only the high part's residue
	// modulo 360 survives into the low 32 quotient bits.
	assign ang    = s_tdata[223:192];
	assign ang_hi = ang >>> FRAC_BITS;
	assign hu     = ang_hi[HU_W-1:0] + HU_OFFSET;
	assign ang_lo = (s_tdata[223:192] << (COORD_W - FRAC_BITS)) | LOW_BIAS;

	always_comb begin
		side_in.axis = axis_t'(s_tuser);
		side_in.pt_x = s_tdata[31:0];
		side_in.pt_y = s_tdata[63:32];
		side_in.pt_z = s_tdata[95:64];
		unique case (side_in.axis)
			AXIS_X: begin
				side_in.cen_c = s_tdata[191:160];
				side_in.cen_s = s_tdata[159:128];
			end
			AXIS_Y: begin
				side_in.cen_c = s_tdata[191:160];
				side_in.cen_s = s_tdata[127:96];
			end
			default: begin
				side_in.cen_c = s_tdata[159:128];
				side_in.cen_s = s_tdata[127:96];
			end
		endcase
	end

	assign hq_lo  = hprod_s2[HU_SHIFT +: MOD_W];
	assign hr_est = hu_lo_s2 - MOD_W'(hq_lo * DEG_MOD);
	assign hr_fix = (hr_est >= DEG_MOD) ? hr_est - DEG_MOD : hr_est;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (pipe_en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s1  <= side_in;
			hu_s1    <= hu;
			low_s1   <= ang_lo;
			side_s2  <= side_s1;
			hprod_s2 <= HPROD_W'(hu_s1) * HPROD_W'(HU_RECIP);
			hu_lo_s2 <= hu_s1[MOD_W-1:0];
			low_s2   <= low_s1;
			side_s3  <= side_s2;
			rem_s3   <= hr_fix[REM_W-1:0];
			low_s3   <= low_s2;
		end
	end

	assign d_valid[0] = valid_s3;
	assign d_side[0]  = side_s3;
	assign d_rem[0]   = rem_s3;
	assign d_low[0]   = low_s3;
	assign d_quo[0]   = '0;

	for (genvar i = 0; i < TURN_DIGITS; i++) begin : g_div
		par_div_cell u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (pipe_en),
			.in_valid  (d_valid[i]),
			.in_side   (d_side[i]),
			.in_rem    (d_rem[i]),
			.in_low    (d_low[i]),
			.in_quo    (d_quo[i]),
			.out_valid (d_valid[i+1]),
			.out_side  (d_side[i+1]),
			.out_rem   (d_rem[i+1]),
			.out_low   (d_low[i+1]),
			.out_quo   (d_quo[i+1])
		);
	end

	// Turns beyond a quarter are folded by negating the vector.
	assign z_turn = ANGLE_W'($signed(d_quo[TURN_DIGITS]));

	always_comb begin
		if (z_turn > QUARTER_TURN) begin
			flip   = 1'b1;
			z_fold = z_turn - HALF_TURN;
		end else if (z_turn < -QUARTER_TURN) begin
			flip   = 1'b1;
			z_fold = z_turn + HALF_TURN;
		end else begin
			flip   = 1'b0;
			z_fold = z_turn;
		end
	end

	always_comb begin
		unique case (d_side[TURN_DIGITS].axis)
			AXIS_X: begin
				pc = d_side[TURN_DIGITS].pt_z;
				ps = d_side[TURN_DIGITS].pt_y;
			end
			AXIS_Y: begin
				pc = d_side[TURN_DIGITS].pt_z;
				ps = d_side[TURN_DIGITS].pt_x;
			end
			default: begin
				pc = d_side[TURN_DIGITS].pt_y;
				ps = d_side[TURN_DIGITS].pt_x;
			end
		endcase
	end

	assign dc   = (COORD_W+1)'(pc) - (COORD_W+1)'(d_side[TURN_DIGITS].cen_c);
	assign ds   = (COORD_W+1)'(ps) - (COORD_W+1)'(d_side[TURN_DIGITS].cen_s);
	assign dc_f = flip ? -dc : dc;
	assign ds_f = flip ? -ds : ds;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_valid[0] <= 1'b0;
		end else if (pipe_en) begin
			c_valid[0] <= d_valid[TURN_DIGITS];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			c_side[0] <= d_side[TURN_DIGITS];
			c_x[0]    <= {(CORDIC_W-GUARD_BITS)'(dc_f), {GUARD_BITS{1'b0}}};
			c_y[0]    <= {(CORDIC_W-GUARD_BITS)'(ds_f), {GUARD_BITS{1'b0}}};
			c_z[0]    <= z_fold;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		par_cordic_cell #(
			.STAGE (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (pipe_en),
			.in_valid  (c_valid[i]),
			.in_side   (c_side[i]),
			.in_x      (c_x[i]),
			.in_y      (c_y[i]),
			.in_z      (c_z[i]),
			.out_valid (c_valid[i+1]),
			.out_side  (c_side[i+1]),
			.out_x     (c_x[i+1]),
			.out_y     (c_y[i+1]),
			.out_z     (c_z[i+1])
		);
	end

	par_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (c_valid[CORDIC_STAGES]),
		.in_side   (c_side[CORDIC_STAGES]),
		.in_x      (c_x[CORDIC_STAGES]),
		.in_y      (c_y[CORDIC_STAGES]),
		.out_valid (g_valid),
		.out_res   (g_res)
	);

	// Output register with a skid register behind it. The pipeline only
	// freezes while the skid register is occupied.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= g_valid;
			end
		end else if (g_valid && pipe_en) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_q <= skid_valid_q ? skid_q : g_res;
		end else if (pipe_en) begin
			skid_q <= g_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.new_z, out_q.new_y, out_q.new_x};
	assign m_tuser  = out_q.saturated;

endmodule

[rtl/par_div_cell.sv]
// One digit step of the degree-to-turn conversion: divides the running
// remainder and the next byte by 360 in two stages.
// Depends on par_pkg.
module par_div_cell
	import par_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  side_t              in_side,
	input  logic [REM_W-1:0]   in_rem,
	input  logic [COORD_W-1:0] in_low,
	input  logic [COORD_W-1:0] in_quo,
	output logic               out_valid,
	output side_t              out_side,
	output logic [REM_W-1:0]   out_rem,
	output logic [COORD_W-1:0] out_low,
	output logic [COORD_W-1:0] out_quo
);

	logic [DIG_V_W-1:0]    dividend;
	logic [DIG_PROD_W-1:0] prod;

	logic                  valid_s1;
	side_t                 side_s1;
	logic [DIG_PROD_W-1:0] prod_s1;
	logic [MOD_W-1:0]      v_lo_s1;
	logic [COORD_W-1:0]    low_s1;
	logic [COORD_W-1:0]    quo_s1;

	logic [DIG_W-1:0] q_est;
	logic [MOD_W-1:0] q_times;
	logic [MOD_W-1:0] r_est;
	logic [DIG_W-1:0] q_fix;
	logic [MOD_W-1:0] r_fix;

	logic                  valid_s2;
	side_t                 side_s2;
	logic [REM_W-1:0]      rem_s2;
	logic [COORD_W-1:0]    low_s2;
	logic [COORD_W-1:0]    quo_s2;

	assign dividend = {in_rem, in_low[COORD_W-1 -: DIG_W]};
	assign prod     = DIG_PROD_W'(dividend) * DIG_PROD_W'(DIG_RECIP);

	// The reciprocal estimate is low by at most one, so one correction suffices.
	// The remainder is below 720 and is worked out modulo 1024.
	assign q_est   = prod_s1[DIG_SHIFT +: DIG_W];
	assign q_times = MOD_W'({2'b00, q_est} * DEG_MOD);
	assign r_est   = v_lo_s1 - q_times;

	always_comb begin
		if (r_est >= DEG_MOD) begin
			q_fix = q_est + DIG_W'(1);
			r_fix = r_est - DEG_MOD;
		end else begin
			q_fix = q_est;
			r_fix = r_est;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			prod_s1 <= prod;
			v_lo_s1 <= dividend[MOD_W-1:0];
			low_s1  <= in_low << DIG_W;
			quo_s1  <= in_quo;
			side_s2 <= side_s1;
			rem_s2  <= r_fix[REM_W-1:0];
			low_s2  <= low_s1;
			quo_s2  <= {quo_s1[COORD_W-DIG_W-1:0], q_fix};
		end
	end

	assign out_valid = valid_s2;
	assign out_side  = side_s2;
	assign out_rem   = rem_s2;
	assign out_low   = low_s2;
	assign out_quo   = quo_s2;

endmodule

[rtl/par_cordic_cell.sv]
// One CORDIC micro-rotation in rotation mode, registered.
// Depends on par_pkg for widths and the arctangent table.
module par_cordic_cell
	import par_pkg::*;
#(
	parameter int STAGE = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  side_t                      in_side,
	input  logic signed [CORDIC_W-1:0] in_x,
	input  logic signed [CORDIC_W-1:0] in_y,
	input  logic signed [ANGLE_W-1:0]  in_z,
	output logic                       out_valid,
	output side_t                      out_side,
	output logic signed [CORDIC_W-1:0] out_x,
	output logic signed [CORDIC_W-1:0] out_y,
	output logic signed [ANGLE_W-1:0]  out_z
);

	localparam logic signed [ANGLE_W-1:0] ATAN_STEP = {2'b00, ATAN_TURN[STAGE]};

	logic signed [CORDIC_W-1:0] x_shr;
	logic signed [CORDIC_W-1:0] y_shr;
	logic signed [CORDIC_W-1:0] x_nxt;
	logic signed [CORDIC_W-1:0] y_nxt;
	logic signed [ANGLE_W-1:0]  z_nxt;

	logic                       valid_q;
	side_t                      side_q;
	logic signed [CORDIC_W-1:0] x_q;
	logic signed [CORDIC_W-1:0] y_q;
	logic signed [ANGLE_W-1:0]  z_q;

	assign x_shr = in_x >>> STAGE;
	assign y_shr = in_y >>> STAGE;

	always_comb begin
		if (!in_z[ANGLE_W-1]) begin
			x_nxt = in_x - y_shr;
			y_nxt = in_y + x_shr;
			z_nxt = in_z - ATAN_STEP;
		end else begin
			x_nxt = in_x + y_shr;
			y_nxt = in_y - x_shr;
			z_nxt = in_z + ATAN_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= in_side;
			x_q    <= x_nxt;
			y_q    <= y_nxt;
			z_q    <= z_nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_side  = side_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;

endmodule

[rtl/par_gain.sv]
// Gain compensation, rounding, centre add-back and saturation of the
// rotated plane components, in three stages. Depends on par_pkg.
module par_gain
	import par_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  side_t                      in_side,
	input  logic signed [CORDIC_W-1:0] in_x,
	input  logic signed [CORDIC_W-1:0] in_y,
	output logic                       out_valid,
	output result_t                    out_res
);

	localparam int PW    = CORDIC_W + GAIN_BITS + 1;
	localparam int SUM_W = 40;
	localparam int SHIFT = GUARD_BITS + GAIN_BITS;
	localparam logic signed [PW-1:0] ROUND_BIAS = PW'(1) << (SHIFT - 1);
	localparam logic signed [GAIN_BITS:0] GAIN_S = {1'b0, GAIN_K};

	function automatic logic ovf(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-COORD_W:0] top;
		top = v[SUM_W-1:COORD_W-1];
		return !((&top) || (~|top));
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp(input logic signed [SUM_W-1:0] v);
		logic signed [COORD_W-1:0] lim;
		lim = v[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		return ovf(v) ? lim : v[COORD_W-1:0];
	endfunction

	logic signed [PW-1:0] prod_c;
	logic signed [PW-1:0] prod_s;
	logic signed [PW-1:0] rnd_c;
	logic signed [PW-1:0] rnd_s;

	logic                 valid_s1;
	side_t                side_s1;
	logic signed [PW-1:0] prod_c_s1;
	logic signed [PW-1:0] prod_s_s1;

	logic                    valid_s2;
	side_t                   side_s2;
	logic signed [SUM_W-1:0] sum_c_s2;
	logic signed [SUM_W-1:0] sum_s_s2;

	logic                      valid_s3;
	result_t                   res_s3;
	result_t                   res_nxt;
	logic signed [COORD_W-1:0] nc;
	logic signed [COORD_W-1:0] ns;
	logic                      any_ovf;

	assign prod_c = PW'(in_x) * PW'(GAIN_S);
	assign prod_s = PW'(in_y) * PW'(GAIN_S);

	// Adding half an LSB before the floor shift rounds half up.
	assign rnd_c = (prod_c_s1 + ROUND_BIAS) >>> SHIFT;
	assign rnd_s = (prod_s_s1 + ROUND_BIAS) >>> SHIFT;

	assign nc      = clamp(sum_c_s2);
	assign ns      = clamp(sum_s_s2);
	assign any_ovf = ovf(sum_c_s2) || ovf(sum_s_s2);

	always_comb begin
		res_nxt.new_x     = side_s2.pt_x;
		res_nxt.new_y     = side_s2.pt_y;
		res_nxt.new_z     = side_s2.pt_z;
		res_nxt.saturated = 1'b0;
		unique case (side_s2.axis)
			AXIS_X: begin
				res_nxt.new_y     = ns;
				res_nxt.new_z     = nc;
				res_nxt.saturated = any_ovf;
			end
			AXIS_Y: begin
				res_nxt.new_x     = ns;
				res_nxt.new_z     = nc;
				res_nxt.saturated = any_ovf;
			end
			AXIS_Z: begin
				res_nxt.new_x     = ns;
				res_nxt.new_y     = nc;
				res_nxt.saturated = any_ovf;
			end
			default: begin
				res_nxt.saturated = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1   <= in_side;
			prod_c_s1 <= prod_c;
			prod_s_s1 <= prod_s;
			side_s2   <= side_s1;
			sum_c_s2  <= SUM_W'(rnd_c) + SUM_W'(side_s1.cen_c);
			sum_s_s2  <= SUM_W'(rnd_s) + SUM_W'(side_s1.cen_s);
			res_s3    <= res_nxt;
		end
	end

	assign out_valid = valid_s3;
	assign out_res   = res_s3;

endmodule

[dv/point_axis_rotator_checker.sv]
// Scoreboard for the point rotator: watches both stream channels, predicts each
// rotated point with a bit-exact CORDIC model and compares it with the block.
// Depends on par_pkg for the arctangent table, gain constant and result struct.
module point_axis_rotator_checker
	import par_pkg::*;
#(
	parameter int CORDIC_STAGES = 16,
	parameter int FRAC_BITS     = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	// point_x, point_y, point_z, centre_x, centre_y, centre_z, angle_deg
	input  logic [223:0] s_tdata,
	// cmd
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	// new_x, new_y, new_z
	input  logic [95:0]  m_tdata,
	// saturated
	input  logic [0:0]   m_tuser,
	output int           mismatches,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	result_t expected_points [$];

	// Reduces the angle modulo 360 degrees and maps it onto a 32-bit binary turn.
	function automatic logic signed [31:0] degrees_to_turn(logic signed [31:0] deg);
		longint     modulus;
		longint     rem;
		logic [63:0] t;
		modulus = longint'(360) << FRAC_BITS;
		rem = longint'(deg) % modulus;
		if (rem < 0) begin
			rem += modulus;
		end
		t = ((rem << (32 - FRAC_BITS)) + 180) / 360;
		return t[31:0];
	endfunction

	function automatic void rotate_plane(input longint dc, input longint ds,
			input logic signed [31:0] turn, output longint oc, output longint os);
		longint x, y, z, xs, ys, at, gain, half;
		x = dc;
		y = ds;
		z = turn;
		gain = GAIN_K;
		half = 64'sd1 <<< (GUARD_BITS + GAIN_BITS - 1);
		// Angles beyond a quarter turn are folded by negating the vector.
		if (z > QUARTER_TURN) begin
			x = -x;
			y = -y;
			z -= HALF_TURN;
		end else if (z < -QUARTER_TURN) begin
			x = -x;
			y = -y;
			z += HALF_TURN;
		end
		x = x <<< GUARD_BITS;
		y = y <<< GUARD_BITS;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			at = ATAN_TURN[i % 32];
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z -= at;
			end else begin
				x = x + ys;
				y = y - xs;
				z += at;
			end
		end
		oc = (x * gain + half) >>> (GUARD_BITS + GAIN_BITS);
		os = (y * gain + half) >>> (GUARD_BITS + GAIN_BITS);
	endfunction

	// Returns the clamp flag in the top bit and the clamped coordinate below it.
	function automatic logic [32:0] clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return {1'b1, 32'h7fff_ffff};
		end
		if (v < -64'sd2147483648) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, v[31:0]};
	endfunction

	function automatic result_t rotate_point(logic [1:0] axis, logic [223:0] item);
		longint            px, py, pz, cx, cy, cz, nc, ns;
		logic signed [31:0] turn;
		logic [32:0]       sine_out, cos_out;
		result_t           r;
		px = $signed(item[31:0]);
		py = $signed(item[63:32]);
		pz = $signed(item[95:64]);
		cx = $signed(item[127:96]);
		cy = $signed(item[159:128]);
		cz = $signed(item[191:160]);
		turn = degrees_to_turn(item[223:192]);
		r.new_x = item[31:0];
		r.new_y = item[63:32];
		r.new_z = item[95:64];
		r.saturated = 1'b0;
		case (axis)
			AXIS_X: begin
				rotate_plane(pz - cz, py - cy, turn, nc, ns);
				sine_out = clamp32(ns + cy);
				cos_out = clamp32(nc + cz);
				r.new_y = sine_out[31:0];
				r.new_z = cos_out[31:0];
				r.saturated = sine_out[32] | cos_out[32];
			end
			AXIS_Y: begin
				rotate_plane(pz - cz, px - cx, turn, nc, ns);
				sine_out = clamp32(ns + cx);
				cos_out = clamp32(nc + cz);
				r.new_x = sine_out[31:0];
				r.new_z = cos_out[31:0];
				r.saturated = sine_out[32] | cos_out[32];
			end
			AXIS_Z: begin
				rotate_plane(py - cy, px - cx, turn, nc, ns);
				sine_out = clamp32(ns + cx);
				cos_out = clamp32(nc + cy);
				r.new_x = sine_out[31:0];
				r.new_y = cos_out[31:0];
				r.saturated = sine_out[32] | cos_out[32];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h, got %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_points.push_back(rotate_point(s_tuser, s_tdata));
			end
			if (m_tvalid && m_tready) begin
				if (expected_points.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result %h, none expected", $time, m_tdata);
				end else begin
					want = expected_points.pop_front();
					compare_field("new_x", want.new_x, m_tdata[31:0]);
					compare_field("new_y", want.new_y, m_tdata[63:32]);
					compare_field("new_z", want.new_z, m_tdata[95:64]);
					compare_field("saturated", 32'(want.saturated), 32'(m_tuser));
				end
			end
			pending = expected_points.size();
		end
	end

endmodule

[dv/point_axis_rotator_test.sv]
// Top of the point rotator testbench: clock, reset, stimulus and verdict.
// Instantiates point_axis_rotator and point_axis_rotator_checker; uses par_pkg.
module point_axis_rotator_test;
	import par_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CORDIC_STAGES = 16;
	localparam int FRAC_BITS     = 16;
	localparam int RANDOM_POINTS = 1600;

	localparam logic [1:0]  AXIS_UNUSED = 2'd3;
	localparam logic [31:0] ONE    = 32'h0001_0000;
	localparam logic [31:0] C_MAX  = 32'h7fff_ffff;
	localparam logic [31:0] C_MIN  = 32'h8000_0000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [223:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         steady = 1'b0;
	int           mismatches;
	int           pending;

	point_axis_rotator #(
		.CORDIC_STAGES(CORDIC_STAGES),
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	point_axis_rotator_checker #(
		.CORDIC_STAGES(CORDIC_STAGES),
		.FRAC_BITS(FRAC_BITS)
	) scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The receiver stalls at random except during the steady stretch.
	always @(posedge clk) begin
		m_tready <= arst_n && (steady || $urandom_range(0, 99) >= 17);
	end

	function automatic logic [31:0] degrees(int d);
		return 32'(d <<< FRAC_BITS);
	endfunction

	// Coordinates within a signed span of the given width, with extremes mixed in.
	function automatic logic [31:0] pick_coord(int bits);
		logic [31:0] v;
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 4))
				0: return C_MIN;
				1: return C_MAX;
				2: return 32'd0;
				3: return 32'hffff_ffff;
				default: return 32'd1;
			endcase
		end
		v = $urandom;
		if (bits < 32) begin
			v = 32'($signed(v << (32 - bits)) >>> (32 - bits));
		end
		return v;
	endfunction

	function automatic logic [31:0] pick_angle();
		int quarter;
		quarter = 90 << FRAC_BITS;
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'((int'($urandom_range(0, 16)) - 8) * quarter);
			// Just around a quadrant boundary, where the fold decision flips.
			2: return 32'((int'($urandom_range(0, 16)) - 8) * quarter
					+ int'($urandom_range(0, 6)) - 3);
			3: return 32'(int'($urandom_range(0, 1440 << FRAC_BITS)) - (720 << FRAC_BITS));
			4: begin
				case ($urandom_range(0, 3))
					0: return C_MIN;
					1: return C_MAX;
					2: return 32'd0;
					default: return degrees(360);
				endcase
			end
			default: return 32'(int'($urandom_range(0, 2 << FRAC_BITS)) - (1 << FRAC_BITS));
		endcase
	endfunction

	task automatic send_point(input logic [1:0] cmd, input logic [31:0] px, py, pz,
			input logic [31:0] cx, cy, cz, ang);
		while (!steady && $urandom_range(0, 99) < 17) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {ang, cz, cy, cx, pz, py, px};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int          bits;
		logic [1:0]  cmd;
		logic [31:0] px, py, pz, cx, cy, cz;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_point(AXIS_X, 32'd0, ONE, 2 * ONE, 32'd0, 32'd0, 32'd0, degrees(90));
		send_point(AXIS_Y, ONE, 32'd0, 2 * ONE, 32'd0, 32'd0, 32'd0, degrees(90));
		send_point(AXIS_Z, ONE, 2 * ONE, 32'd0, 32'd0, 32'd0, 32'd0, degrees(90));
		send_point(AXIS_X, 3 * ONE, ONE, ONE, ONE, 32'd0, 32'd0, 32'd0);
		send_point(AXIS_Y, 5 * ONE, -ONE, 7 * ONE, ONE, ONE, -ONE, degrees(180));
		send_point(AXIS_Z, -3 * ONE, 4 * ONE, ONE, ONE, -ONE, 32'd0, degrees(-90));
		send_point(AXIS_X, ONE, 9 * ONE, -2 * ONE, 32'd0, ONE, ONE, degrees(270));
		send_point(AXIS_Y, 2 * ONE, ONE, 3 * ONE, 32'd0, 32'd0, 32'd0, degrees(360));
		send_point(AXIS_Z, 6 * ONE, -6 * ONE, ONE, 32'd0, 32'd0, 32'd0, degrees(-180));
		send_point(AXIS_X, ONE, ONE, ONE, 32'd0, 32'd0, 32'd0, degrees(45));
		send_point(AXIS_Y, 8 * ONE, ONE, 8 * ONE, 32'd0, 32'd0, 32'd0, degrees(90) + 1);
		send_point(AXIS_Z, 8 * ONE, 8 * ONE, ONE, 32'd0, 32'd0, 32'd0, degrees(-90) - 1);
		// Unused axis code: the point must come back untouched.
		send_point(AXIS_UNUSED, C_MAX, C_MIN, ONE, ONE, ONE, ONE, degrees(30));
		// Point sitting on the centre.
		send_point(AXIS_Z, 3 * ONE, -ONE, ONE, 3 * ONE, -ONE, ONE, degrees(45));
		send_point(AXIS_X, 32'd0, ONE, -ONE, 32'd0, 32'd0, 32'd0, C_MIN);
		send_point(AXIS_Y, ONE, 32'd0, -ONE, 32'd0, 32'd0, 32'd0, C_MAX);
		send_point(AXIS_Z, C_MAX, C_MAX, 32'd0, C_MIN, C_MIN, 32'd0, degrees(45));
		send_point(AXIS_X, 32'd0, C_MIN, C_MIN, 32'd0, C_MAX, C_MAX, degrees(90));
		send_point(AXIS_Y, C_MAX, 32'd5, C_MIN, C_MIN, 32'd5, C_MAX, degrees(180));
		send_point(AXIS_Z, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);

		for (int n = 0; n < RANDOM_POINTS; n++) begin
			steady <= (n >= 600 && n < 900);
			case ($urandom_range(0, 4))
				0: bits = 12;
				1: bits = 20;
				2: bits = 28;
				3: bits = 31;
				default: bits = 32;
			endcase
			cmd = ($urandom_range(0, 19) == 0) ? AXIS_UNUSED : 2'($urandom_range(0, 2));
			px = pick_coord(bits);
			py = pick_coord(bits);
			pz = pick_coord(bits);
			cx = pick_coord(bits);
			cy = pick_coord(bits);
			cz = pick_coord(bits);
			if ($urandom_range(0, 11) == 0) begin
				cx = px;
				cy = py;
				cz = pz;
			end
			send_point(cmd, px, py, pz, cx, cy, cz, pick_angle());
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (CORDIC_STAGES + 20) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("tb: failure");
		$finish;
	end

endmodule
